[rtl/fba_pkg.sv]
// shared constants and codes for the frame bitmap allocator
package fba_pkg;

  localparam int FRAME_W    = 13;
  localparam int ADDR_BITS  = 32;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;

  localparam int DEF_MAX_FRAMES    = 4096;
  localparam int DEF_PAGE_SHIFT    = 12;
  localparam int DEF_MAP_WORD_BITS = 32;

  localparam logic [FRAME_W-1:0] COUNT_RESET = FRAME_W'(4096);

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TEST    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

[rtl/fba_cmd_if.sv]
// command channel: operation and frame address
interface fba_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::CMD_W-1:0]     command;
  logic [fba_pkg::ADDR_BITS-1:0] frame_address;

  modport source (output valid, command, frame_address, input ready);
  modport sink   (input valid, command, frame_address, output ready);
endinterface

[rtl/fba_rsp_if.sv]
// response channel: allocated address, status and used flag
interface fba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::ADDR_BITS-1:0] result_address;
  logic [fba_pkg::STATUS_W-1:0]  status;
  logic                          frame_used;

  modport source (output valid, result_address, status, frame_used, input ready);
  modport sink   (input valid, result_address, status, frame_used, output ready);
endinterface

[rtl/fba_cfg_if.sv]
// configuration write channel for the frame count register
interface fba_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fba_pkg::FRAME_W-1:0] frame_count;

  modport source (output valid, frame_count, input ready);
  modport sink   (input valid, frame_count, output ready);
endinterface

[rtl/fba_ram.sv]
// generic single write port, single read port ram with registered read
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/fba_divider.sv]
// word and bit split of a frame index by the map word width, reciprocal multiply, registered result
module fba_divider #(
  parameter int DIVISOR = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fba_pkg::FRAME_W-1:0] dividend,
  output logic                        done,
  output logic [fba_pkg::FRAME_W-1:0] quotient,
  output logic [$clog2(DIVISOR)-1:0]  remainder
);
  import fba_pkg::*;

  localparam int RW = $clog2(DIVISOR);
  localparam int MW = FRAME_W + 1;
  localparam int PW = FRAME_W + MW;
  localparam int SH = FRAME_W + RW;
  // ceiling of 2^SH over the divisor, exact for every FRAME_W-bit dividend
  localparam logic [MW-1:0] RECIP_C =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam logic [FRAME_W-1:0] DIV_C = FRAME_W'(DIVISOR);

  logic [PW-1:0]      prod;
  logic [FRAME_W-1:0] quo_c;
  logic [FRAME_W-1:0] rem_c;

  assign prod  = PW'(dividend) * PW'(RECIP_C);
  assign quo_c = FRAME_W'(prod >> SH);
  assign rem_c = dividend - quo_c * DIV_C;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= quo_c;
      remainder <= rem_c[RW-1:0];
    end
  end

endmodule

[rtl/frame_bitmap_allocator_top.sv]
// frame bitmap allocator: next-fit alloc, free, reserve and test over a word-wide bitmap
// alloc: split of the frame count, then the scan reads one map word per cycle
//   with a priority encoder, then the result goes to the response register
// free, reserve, test: index split, map read, then read-modify-write for free and reserve
// out-of-range address: response straight from idle, no split or map access; one command at a time
// reset: after rst the map is zeroed one word per cycle, all 128 words at default size, cmd not ready
module frame_bitmap_allocator_top #(
  parameter int MAX_FRAMES    = fba_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_SHIFT    = fba_pkg::DEF_PAGE_SHIFT,
  parameter int MAP_WORD_BITS = fba_pkg::DEF_MAP_WORD_BITS
) (
  input logic          clk,
  input logic          rst,
  fba_cmd_if.sink      cmd,
  fba_rsp_if.source    rsp,
  fba_cfg_if.sink      cfg
);
  import fba_pkg::*;

  localparam int FRAME_LIMIT = (MAX_FRAMES < (1 << FRAME_W)) ? MAX_FRAMES : (1 << FRAME_W) - 1;
  localparam int USED_WORDS  = (FRAME_LIMIT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int ADDR_W      = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
  localparam int CW_W        = $clog2(USED_WORDS + 1);
  localparam int BIT_W       = $clog2(MAP_WORD_BITS);
  localparam int AF_W        = ADDR_BITS - PAGE_SHIFT;

  localparam logic [FRAME_W-1:0] LIMIT_C    = FRAME_W'(FRAME_LIMIT);
  localparam logic [FRAME_W-1:0] WBITS_C    = FRAME_W'(MAP_WORD_BITS);
  localparam logic [ADDR_W-1:0]  LAST_ROW_C = ADDR_W'(USED_WORDS - 1);
  localparam logic [BIT_W-1:0]   TOP_BIT_C  = BIT_W'(MAP_WORD_BITS - 1);
  localparam logic [CW_W-1:0]    WONE_C     = CW_W'(1);
  localparam logic [MAP_WORD_BITS-1:0] BIT0_C = MAP_WORD_BITS'(1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CDIV  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FDIV  = 3'd4;
  localparam logic [2:0] S_FMOD  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]          state;
  logic [ADDR_W-1:0]   clr_addr;
  logic [FRAME_W-1:0]  frame_count;
  logic [CMD_W-1:0]    cmd_r;

  // hint kept as word and bit, always with bit below the word width
  logic [CW_W-1:0]     hint_word;
  logic [BIT_W-1:0]    hint_bit;
  logic [CW_W-1:0]     cnt_word;
  logic [BIT_W-1:0]    cnt_bit;
  logic [CW_W-1:0]     start_word;
  logic [BIT_W-1:0]    start_bit;

  logic [CW_W-1:0]     iss_w;
  logic                iss_pass;
  logic                iss_on;
  logic [CW_W-1:0]     chk_w;
  logic                chk_pass;
  logic                chk_vld;

  logic [ADDR_BITS-1:0] res_addr;
  logic [STATUS_W-1:0]  res_status;
  logic                 res_used;
  logic                 resp_load;

  logic [FRAME_W-1:0]  count_eff;
  logic [AF_W-1:0]     frame64;
  logic                out_of_range;

  logic                div_start;
  logic [FRAME_W-1:0]  div_dividend;
  logic                div_done;
  logic [FRAME_W-1:0]  div_quo;
  logic [BIT_W-1:0]    div_rem;
  logic [CW_W-1:0]     div_word;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata;
  logic                     ram_re;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_rdata;

  logic                     hint_lt;
  logic [CW_W-1:0]          div_nw;
  logic [CW_W-1:0]          scan_nw;
  logic [MAP_WORD_BITS-1:0] avail;
  logic                     found;
  logic [BIT_W-1:0]         found_bit;
  logic [FRAME_W-1:0]       found_frame;
  logic [MAP_WORD_BITS-1:0] found_mask;
  logic [MAP_WORD_BITS-1:0] op_mask;
  logic                     frame_below_hint;

  assign count_eff    = (frame_count > LIMIT_C) ? LIMIT_C : frame_count;
  assign frame64      = cmd.frame_address[ADDR_BITS-1:PAGE_SHIFT];
  assign out_of_range = frame64 >= AF_W'(count_eff);
  assign div_dividend = (cmd.command == CMD_ALLOC) ? count_eff : frame64[FRAME_W-1:0];
  assign div_word     = div_quo[CW_W-1:0];

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  fba_divider #(
    .DIVISOR (MAP_WORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  fba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (USED_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scan start point once the count is split into word and bit
  assign hint_lt = (hint_word < div_word) || ((hint_word == div_word) && (hint_bit < div_rem));
  assign div_nw  = div_word + CW_W'(div_rem != '0);
  assign scan_nw = cnt_word + CW_W'(cnt_bit != '0);

  // free bits of the checked word inside the count and on the right side of the start
  always_comb begin
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      avail[b] = ~ram_rdata[b]
               & ((chk_w < cnt_word) || ((chk_w == cnt_word) && (BIT_W'(b) < cnt_bit)))
               & ((chk_w != start_word)
                  || (chk_pass ? (BIT_W'(b) < start_bit) : (BIT_W'(b) >= start_bit)));
    end
  end

  always_comb begin
    found_bit = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        found_bit = BIT_W'(b);
      end
    end
  end

  assign found       = chk_vld && (avail != '0);
  assign found_frame = FRAME_W'(chk_w) * WBITS_C + FRAME_W'(found_bit);
  assign found_mask  = BIT0_C << found_bit;
  assign op_mask     = BIT0_C << div_rem;
  assign frame_below_hint = (div_word < hint_word)
                          || ((div_word == hint_word) && (div_rem < hint_bit));

  // response register loads in S_RESP when it is empty or its beat leaves this cycle
  assign resp_load = (state == S_RESP) && (!rsp.valid || rsp.ready);

  always_comb begin
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = iss_w[ADDR_W-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        div_start = cmd.valid && ((cmd.command == CMD_ALLOC) || !out_of_range);
      end
      S_SCAN: begin
        ram_re    = iss_on;
        ram_we    = found;
        ram_waddr = chk_w[ADDR_W-1:0];
        ram_wdata = ram_rdata | found_mask;
      end
      S_FDIV: begin
        ram_re    = div_done;
        ram_raddr = div_word[ADDR_W-1:0];
      end
      S_FMOD: begin
        ram_waddr = div_word[ADDR_W-1:0];
        if (cmd_r == CMD_FREE) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~op_mask;
        end else if (cmd_r == CMD_RESERVE) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | op_mask;
        end
      end
      S_CDIV, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= COUNT_RESET;
    end else if (cfg.valid) begin
      frame_count <= cfg.frame_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      hint_word <= '0;
      hint_bit  <= '0;
      iss_on    <= 1'b0;
      chk_vld   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ROW_C) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_r      <= cmd.command;
            res_addr   <= '0;
            res_used   <= 1'b0;
            res_status <= ((cmd.command != CMD_ALLOC) && out_of_range) ? ST_RANGE : ST_OK;
            if (cmd.command == CMD_ALLOC) begin
              state <= S_CDIV;
            end else if (out_of_range) begin
              state <= S_RESP;
            end else begin
              state <= S_FDIV;
            end
          end
        end
        S_CDIV: begin
          if (div_done) begin
            cnt_word   <= div_word;
            cnt_bit    <= div_rem;
            start_word <= hint_lt ? hint_word : '0;
            start_bit  <= hint_lt ? hint_bit : '0;
            iss_on     <= 1'b1;
            chk_vld    <= 1'b0;
            // empty first pass only when the count is zero
            if ((hint_lt ? hint_word : '0) < div_nw) begin
              iss_pass <= 1'b0;
              iss_w    <= hint_lt ? hint_word : '0;
            end else begin
              iss_pass <= 1'b1;
              iss_w    <= '0;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          chk_w    <= iss_w;
          chk_pass <= iss_pass;
          if (found) begin
            iss_on   <= 1'b0;
            chk_vld  <= 1'b0;
            res_addr <= ADDR_BITS'(found_frame) << PAGE_SHIFT;
            if (found_bit == TOP_BIT_C) begin
              hint_word <= chk_w + WONE_C;
              hint_bit  <= '0;
            end else begin
              hint_word <= chk_w;
              hint_bit  <= found_bit + BIT_W'(1);
            end
            state <= S_RESP;
          end else if (!iss_on) begin
            chk_vld    <= 1'b0;
            res_status <= ST_OOM;
            state      <= S_RESP;
          end else begin
            chk_vld <= 1'b1;
            if (!iss_pass) begin
              if (iss_w + WONE_C == scan_nw) begin
                iss_pass <= 1'b1;
                iss_w    <= '0;
              end else begin
                iss_w <= iss_w + WONE_C;
              end
            end else if (iss_w == start_word) begin
              iss_on <= 1'b0;
            end else begin
              iss_w <= iss_w + WONE_C;
            end
          end
        end
        S_FDIV: begin
          if (div_done) begin
            state <= S_FMOD;
          end
        end
        S_FMOD: begin
          if (cmd_r == CMD_FREE && frame_below_hint) begin
            hint_word <= div_word;
            hint_bit  <= div_rem;
          end
          if (cmd_r == CMD_TEST) begin
            res_used <= ram_rdata[div_rem];
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (resp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (resp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // response payload loads with the beat
  always_ff @(posedge clk) begin
    if (resp_load) begin
      rsp.result_address <= res_addr;
      rsp.status         <= res_status;
      rsp.frame_used     <= res_used;
    end
  end

endmodule

[verif/fba_checker.sv]
// checker for the frame bitmap allocator: models the bitmap and compares each response beat
`timescale 1ns / 100ps
module fba_checker (
  input  logic clk,
  input  logic rst,
  fba_cmd_if   cmd,
  fba_rsp_if   rsp,
  fba_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);
  import fba_pkg::*;

  localparam int PAGE_SHIFT = DEF_PAGE_SHIFT;
  localparam int MAX_FRAMES = DEF_MAX_FRAMES;
  localparam int FI_W       = $clog2(MAX_FRAMES);

  typedef struct packed {
    logic [ADDR_BITS-1:0] result_address;
    logic [STATUS_W-1:0]  status;
    logic                 frame_used;
  } rsp_beat_t;

  logic               frame_map [MAX_FRAMES];
  logic [FRAME_W-1:0] frame_count;
  int                 alloc_hint;
  rsp_beat_t          response_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // next-fit allocator step: updates the bitmap and hint, returns the response beat
  function automatic rsp_beat_t predict_response(input logic [CMD_W-1:0] op,
                                                 input logic [ADDR_BITS-1:0] addr);
    rsp_beat_t                       r;
    int                              limit;
    int                              start;
    int                              found;
    logic [ADDR_BITS-PAGE_SHIFT-1:0] idx;
    r     = '0;
    limit = (int'(frame_count) > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count);
    idx   = addr[ADDR_BITS-1:PAGE_SHIFT];
    if (op == CMD_ALLOC) begin
      // a hint left beyond a lowered count restarts the scan at frame zero
      start = (alloc_hint < limit) ? alloc_hint : 0;
      found = -1;
      for (int i = start; i < limit && found < 0; i++)
        if (!frame_map[FI_W'(i)]) found = i;
      for (int i = 0; i < start && found < 0; i++)
        if (!frame_map[FI_W'(i)]) found = i;
      if (found < 0) begin
        r.status = ST_OOM;
      end else begin
        frame_map[FI_W'(found)] = 1'b1;
        alloc_hint              = found + 1;
        r.result_address        = ADDR_BITS'(found) << PAGE_SHIFT;
      end
    end else if (idx >= limit) begin
      r.status = ST_RANGE;
    end else begin
      case (op)
        CMD_FREE: begin
          frame_map[idx[FI_W-1:0]] = 1'b0;
          if (int'(idx) < alloc_hint) alloc_hint = int'(idx);
        end
        CMD_RESERVE: frame_map[idx[FI_W-1:0]] = 1'b1;
        default: r.frame_used = frame_map[idx[FI_W-1:0]];
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_beat_t want;
    if (rst) begin
      foreach (frame_map[i]) frame_map[i] = 1'b0;
      frame_count = COUNT_RESET;
      alloc_hint  = 0;
      response_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (response_q.size() == 0) begin
          report_error($sformatf("response beat with nothing outstanding: addr %h status %0d",
                                 rsp.result_address, rsp.status));
        end else begin
          want = response_q.pop_front();
          if (rsp.result_address !== want.result_address)
            report_error($sformatf("result_address %h, want %h",
                                   rsp.result_address, want.result_address));
          if (rsp.status !== want.status)
            report_error($sformatf("status %0d, want %0d", rsp.status, want.status));
          if (rsp.frame_used !== want.frame_used)
            report_error($sformatf("frame_used %b, want %b", rsp.frame_used, want.frame_used));
        end
      end
      if (cfg.valid && cfg.ready) frame_count = cfg.frame_count;
      if (cmd.valid && cmd.ready)
        response_q.push_back(predict_response(cmd.command, cmd.frame_address));
    end
    pending <= response_q.size();
  end

endmodule

[verif/tb_top.sv]
// testbench top for the frame bitmap allocator: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
  import fba_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;

  int tx_idle_pct = 6;
  int rx_idle_pct = 53;
  int hold_token  = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int cur_frames  = DEF_MAX_FRAMES;

  fba_cmd_if cmd_ch ();
  fba_rsp_if rsp_ch ();
  fba_cfg_if cfg_ch ();

  frame_bitmap_allocator_top dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  fba_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // response side: random backpressure, plus a long hold-off whenever a new one is requested
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = 800;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [ADDR_BITS-1:0] addr);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.command       <= op;
    cmd_ch.frame_address <= addr;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // the checker's count is registered, so look only once it has caught up
  task automatic wait_drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [FRAME_W-1:0] value);
    wait_drain();
    repeat (4) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.frame_count <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_frames = (int'(value) > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : int'(value);
  endtask

  task automatic send_random();
    logic [CMD_W-1:0]     op;
    logic [ADDR_BITS-1:0] addr;
    int                   pick;
    int                   frame;
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = CMD_ALLOC;
    else if (pick < 65) op = CMD_FREE;
    else if (pick < 80) op = CMD_RESERVE;
    else                op = CMD_TEST;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      addr = $urandom();
    end else begin
      // mostly frames in range, now and then the first frame past the count
      if (pick == 1 || cur_frames == 0) frame = cur_frames;
      else frame = $urandom_range(0, cur_frames - 1);
      addr = (ADDR_BITS'(frame) << DEF_PAGE_SHIFT)
           | ADDR_BITS'($urandom_range(0, (1 << DEF_PAGE_SHIFT) - 1));
    end
    send_cmd(op, addr);
  endtask

  initial begin
    rst                  <= 1'b1;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.command       <= CMD_ALLOC;
    cmd_ch.frame_address <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.frame_count   <= COUNT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // default count: first allocs, ignored page offset, top frame, addresses past the map
    send_cmd(CMD_TEST, 32'h0000_0000);
    send_cmd(CMD_ALLOC, 32'hFFFF_FFFF);
    send_cmd(CMD_ALLOC, 32'h0000_0000);
    send_cmd(CMD_TEST, 32'h0000_0FFF);
    send_cmd(CMD_FREE, 32'h0000_1FFF);
    send_cmd(CMD_RESERVE, 32'hFFFF_F000);
    send_cmd(CMD_TEST, 32'hFFFF_FFFF);
    send_cmd(CMD_RESERVE, 32'h00FF_F000);
    send_cmd(CMD_TEST, 32'h00FF_FFFF);
    send_cmd(CMD_FREE, 32'h0100_0000);
    send_cmd(CMD_FREE, 32'h0000_0000);
    send_cmd(CMD_FREE, 32'h0000_0000);

    // no frames at all
    write_frame_count('0);
    send_cmd(CMD_ALLOC, 32'h0000_0000);
    send_cmd(CMD_TEST, 32'h0000_0000);
    send_cmd(CMD_FREE, 32'h0000_0000);

    // count above the map saturates
    write_frame_count({FRAME_W{1'b1}});
    send_cmd(CMD_TEST, 32'h00FF_F000);
    send_cmd(CMD_FREE, 32'h0100_0000);
    send_cmd(CMD_ALLOC, 32'h0000_0000);
    send_cmd(CMD_RESERVE, 32'h0000_2000);
    send_cmd(CMD_ALLOC, 32'h0000_0000);
    send_cmd(CMD_ALLOC, 32'h0000_0000);

    // hint now past a count of three, map below it full
    write_frame_count(FRAME_W'(3));
    send_cmd(CMD_ALLOC, 32'h0000_0000);
    send_cmd(CMD_FREE, 32'h0000_1000);
    send_cmd(CMD_ALLOC, 32'h0000_0000);
    send_cmd(CMD_ALLOC, 32'h0000_0000);

    for (int ph = 0; ph < 11; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 6;
        rx_idle_pct = 53;
      end else if (ph < 8) begin
        tx_idle_pct = 53;
        rx_idle_pct = 6;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph % 4)
        0:       write_frame_count(FRAME_W'($urandom_range(1, 40)));
        1:       write_frame_count(FRAME_W'($urandom_range(41, 300)));
        2:       write_frame_count(COUNT_RESET);
        default: write_frame_count(FRAME_W'($urandom_range(DEF_MAX_FRAMES + 1, 8191)));
      endcase
      // response side holds off while commands keep coming
      if (ph == 1 || ph == 9) hold_token++;
      repeat (100) send_random();
    end

    wait_drain();
    repeat (160) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
